FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the dispatch sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, disabled while reset is asserted.
`define NDAS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked through reset as well.
`define NDAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NDAS_ASSERT(lbl, clk, rst_n, prop, msg)
`define NDAS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/ndas_pkg.sv
// ----------------------------------------------------------------------------
// ndas_pkg
// Types, widths and codes of the neuron dispatch address sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ndas_pkg;

  localparam int unsigned AddrW       = 24;
  localparam int unsigned SizeW       = 11;
  localparam int unsigned CidW        = 4;
  localparam int unsigned DataW       = 32;
  localparam int unsigned LcW         = 3;
  localparam int unsigned NiW         = 10;
  localparam int unsigned LoadW       = 5;
  localparam int unsigned CmdW        = 2;
  localparam int unsigned KindW       = 2;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned NumSizes    = 7;
  localparam int unsigned MaxSize     = 1024;
  localparam int unsigned NumCoresDef = 4;

  // Command codes
  localparam logic [CmdW-1:0] CMD_START  = 2'd0;
  localparam logic [CmdW-1:0] CMD_TICK   = 2'd1;
  localparam logic [CmdW-1:0] CMD_FREE   = 2'd2;
  localparam logic [CmdW-1:0] CMD_RESULT = 2'd3;

  // Result kinds
  localparam logic [KindW-1:0] KIND_NONE  = 2'd0;
  localparam logic [KindW-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KindW-1:0] KIND_WRITE = 2'd2;
  localparam logic [KindW-1:0] KIND_DONE  = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LAYER_COUNT = 3'd0;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [CidW-1:0]  core_id;
    logic [DataW-1:0] result_value;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CidW-1:0]  target_core;
    logic [SizeW-1:0] data_count;
    logic [AddrW-1:0] weight_addr;
    logic [AddrW-1:0] value_addr;
    logic [AddrW-1:0] write_addr;
    logic [DataW-1:0] write_data;
  } out_item_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic             clr;
    logic             mul;
    logic             acc;
    logic [AddrW-1:0] init;
    logic [SizeW-1:0] a;
    logic [SizeW-1:0] b;
  } mac_ctl_t;

  // Requests to the core pool
  typedef struct packed {
    logic             alloc;
    logic             rel;
    logic [CidW-1:0]  id;
    logic [AddrW-1:0] link;
  } pool_ctl_t;

  // Status from the core pool
  typedef struct packed {
    logic             has_free;
    logic [CidW-1:0]  pick;
    logic [LoadW-1:0] loaded;
    logic [AddrW-1:0] link_rd;
  } pool_sts_t;

  // Clamp a raw layer size into 1..MaxSize.
  function automatic logic [SizeW-1:0] sat_size(input logic [SizeW-1:0] raw);
    logic [SizeW-1:0] s;
    s = raw;
    if (raw == '0) begin
      s = SizeW'(1);
    end else if (raw > SizeW'(MaxSize)) begin
      s = SizeW'(MaxSize);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/neuron_dispatch_address_sequencer.sv
// ----------------------------------------------------------------------------
// neuron_dispatch_address_sequencer
// Hands out neurons of a layered network to compute cores and tracks results.
// ----------------------------------------------------------------------------
// Usage:
//   An item (item_i: cmd, core_id, result_value) is taken at a clock edge
//   where start_i is high and busy_o is low. Every item yields exactly one
//   result on result_o, marked by result_valid_o for a single cycle; the
//   receiver cannot hold it off.
//   Tick, core-free and core-result items take one cycle: the result shows
//   in the cycle after the item is taken, and busy_o stays low, so one of
//   these may be taken in every cycle.
//   A start item runs the layer-product sum through one shared multiplier
//   and accumulator, a product and an add per layer pair: busy_o is high
//   through the S_MUL and S_ADD states of each pair and the closing S_FIN
//   state, and its (empty) result shows in the first cycle with busy_o low again.
//   Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) must be written only
//   while the block is idle; the block itself does not enforce this.
//   Reset clears all counters, pointers, core flags and result links, and
//   restores two layers of size one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module neuron_dispatch_address_sequencer import ndas_pkg::*; #(
  parameter int unsigned NumCores = NumCoresDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire in_item_t           item_i,
  output logic                    result_valid_o,
  output out_item_t               result_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [SizeW-1:0]   cfg_wdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [LcW-1:0]   layer_count_q;
  logic [SizeW-1:0] size_q [NumSizes];

  logic [1:0]       state_q, state_d;
  logic [LcW-1:0]   k_q, k_d;
  logic [LcW-1:0]   li_q, li_d;
  logic [NiW-1:0]   ni_q, ni_d;
  logic [AddrW-1:0] wp_q, wp_d;
  logic [AddrW-1:0] vp_q, vp_d;
  logic             running_q, running_d;
  out_item_t        res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic             accept;
  logic [LcW-1:0]   nl;
  logic [SizeW-1:0] cur;
  logic [SizeW-1:0] nxt;
  logic [AddrW-1:0] vp_cur;
  logic [NiW-1:0]   ni_inc;
  logic             cid_ok;
  logic [AddrW-1:0] acc;

  mac_ctl_t         mac_ctl;
  pool_ctl_t        pool_ctl;
  pool_sts_t        pool_sts;

  function automatic logic [SizeW-1:0] eff_size(input logic [LcW-1:0] k);
    logic [SizeW-1:0] s;
    s = SizeW'(1);
    if (k < LcW'(NumSizes)) begin
      s = sat_size(size_q[k]);
    end
    return s;
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= LcW'(2);
      for (int i = 0; i < NumSizes; i++) begin
        size_q[i] <= SizeW'(1);
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_LAYER_COUNT) begin
        layer_count_q <= cfg_wdata_i[LcW-1:0];
      end else begin
        size_q[cfg_idx_i - CfgIdxW'(1)] <= cfg_wdata_i;
      end
    end
  end

  assign nl     = (layer_count_q < LcW'(2)) ? LcW'(2) : layer_count_q;
  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign cid_ok = ({1'b0, item_i.core_id} < (CidW + 1)'(NumCores));

  // Track size register writes as well as the layer index.
  always_comb begin
    cur = eff_size(li_q);
    nxt = eff_size(li_q + LcW'(1));
  end

  assign vp_cur = vp_q + AddrW'(cur);
  assign ni_inc = ni_q + NiW'(1);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    li_d        = li_q;
    ni_d        = ni_q;
    wp_d        = wp_q;
    vp_d        = vp_q;
    running_d   = running_q;
    res_d       = '0;
    res_valid_d = 1'b0;
    mac_ctl     = '0;
    pool_ctl    = '0;

    mac_ctl.init  = AddrW'(nl) + AddrW'(1);
    mac_ctl.a     = eff_size(k_q);
    mac_ctl.b     = eff_size(k_q + LcW'(1));
    pool_ctl.id   = item_i.core_id;
    pool_ctl.link = vp_cur + AddrW'(ni_q);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.cmd)
            CMD_START: begin
              mac_ctl.clr = 1'b1;
              k_d         = '0;
              state_d     = S_MUL;
            end
            CMD_TICK: begin
              res_valid_d = 1'b1;
              if (running_q) begin
                if (li_q >= nl - LcW'(1)) begin
                  if (pool_sts.loaded == '0) begin
                    res_d.kind       = KIND_DONE;
                    res_d.value_addr = vp_q;
                    running_d        = 1'b0;
                  end
                end else if (pool_sts.has_free) begin
                  pool_ctl.alloc    = 1'b1;
                  res_d.kind        = KIND_LOAD;
                  res_d.target_core = pool_sts.pick;
                  res_d.data_count  = cur;
                  res_d.weight_addr = wp_q;
                  res_d.value_addr  = vp_q;
                  wp_d              = wp_q + AddrW'(cur);
                  // Advance to the next layer once its last neuron is out.
                  if (ni_inc == nxt[NiW-1:0]) begin
                    vp_d = vp_cur;
                    ni_d = '0;
                    li_d = li_q + LcW'(1);
                  end else begin
                    ni_d = ni_inc;
                  end
                end
              end
            end
            CMD_FREE: begin
              res_valid_d  = 1'b1;
              pool_ctl.rel = cid_ok;
            end
            default: begin
              res_valid_d = 1'b1;
              if (cid_ok) begin
                res_d.kind       = KIND_WRITE;
                res_d.write_addr = pool_sts.link_rd;
                res_d.write_data = item_i.result_value;
              end
            end
          endcase
        end
      end
      S_MUL: begin
        mac_ctl.mul = 1'b1;
        state_d     = S_ADD;
      end
      S_ADD: begin
        mac_ctl.acc = 1'b1;
        if (k_q == nl - LcW'(2)) begin
          state_d = S_FIN;
        end else begin
          k_d     = k_q + LcW'(1);
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        wp_d        = AddrW'(nl) + AddrW'(1);
        vp_d        = acc;
        li_d        = '0;
        ni_d        = '0;
        running_d   = 1'b1;
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      li_q        <= '0;
      ni_q        <= '0;
      wp_q        <= '0;
      vp_q        <= '0;
      running_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      li_q        <= li_d;
      ni_q        <= ni_d;
      wp_q        <= wp_d;
      vp_q        <= vp_d;
      running_q   <= running_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  ndas_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .acc_o  (acc)
  );

  ndas_core_pool #(
    .NumCores (NumCores)
  ) u_pool (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pool_ctl),
    .sts_o  (pool_sts)
  );

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `NDAS_ASSERT(a_result_has_cause, clk_i, rst_ni,
    result_valid_o |-> $past(accept && item_i.cmd != CMD_START) || $past(state_q == S_FIN),
    "result strobe without a finished item")
  `NDAS_ASSERT(a_done_only_unloaded, clk_i, rst_ni,
    (result_valid_o && result_o.kind == KIND_DONE) |-> $past(pool_sts.loaded == '0),
    "done reported while cores are loaded")
  `NDAS_ASSERT(a_mul_then_add, clk_i, rst_ni,
    (state_q == S_MUL) |=> (state_q == S_ADD), "product not followed by accumulate")

endmodule

`default_nettype wire

FILE: rtl/ndas_mac.sv
// ----------------------------------------------------------------------------
// ndas_mac
// Shared multiply-accumulate unit: one registered product, then one add.
// ----------------------------------------------------------------------------
`default_nettype none

module ndas_mac import ndas_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mac_ctl_t         ctl_i,
  output logic [AddrW-1:0]      acc_o
);

  logic [2*SizeW-1:0] prod_q;
  logic [AddrW-1:0]   acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctl_i.mul) begin
        prod_q <= ctl_i.a * ctl_i.b;
      end
      if (ctl_i.clr) begin
        acc_q <= ctl_i.init;
      end else if (ctl_i.acc) begin
        acc_q <= acc_q + AddrW'(prod_q);
      end
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

FILE: rtl/ndas_core_pool.sv
// ----------------------------------------------------------------------------
// ndas_core_pool
// Busy flags, free-core pick, loaded count and result links of the cores.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ndas_core_pool import ndas_pkg::*; #(
  parameter int unsigned NumCores = NumCoresDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire pool_ctl_t ctl_i,
  output pool_sts_t      sts_o
);

  localparam int unsigned CoreIdxW = (NumCores > 1) ? $clog2(NumCores) : 1;

  logic [NumCores-1:0] busy_q;
  logic [LoadW-1:0]    loaded_q;
  logic [AddrW-1:0]    link_q [NumCores];

  logic                has_free;
  logic [CidW-1:0]     pick;
  logic [CoreIdxW-1:0] pick_idx;
  logic [CoreIdxW-1:0] id_idx;

  // Highest-numbered free core wins.
  always_comb begin
    has_free = 1'b0;
    pick     = '0;
    for (int i = 0; i < NumCores; i++) begin
      if (!busy_q[i]) begin
        has_free = 1'b1;
        pick     = CidW'(i);
      end
    end
  end

  assign pick_idx = pick[CoreIdxW-1:0];
  assign id_idx   = ctl_i.id[CoreIdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= '0;
      loaded_q <= '0;
      for (int i = 0; i < NumCores; i++) begin
        link_q[i] <= '0;
      end
    end else begin
      if (ctl_i.alloc && has_free) begin
        busy_q[pick_idx] <= 1'b1;
        link_q[pick_idx] <= ctl_i.link;
        loaded_q         <= loaded_q + LoadW'(1);
      end else if (ctl_i.rel && busy_q[id_idx]) begin
        busy_q[id_idx] <= 1'b0;
        loaded_q       <= loaded_q - LoadW'(1);
      end
    end
  end

  assign sts_o.has_free = has_free;
  assign sts_o.pick     = pick;
  assign sts_o.loaded   = loaded_q;
  assign sts_o.link_rd  = link_q[id_idx];

  `NDAS_ASSERT(a_loaded_matches_busy, clk_i, rst_ni,
    loaded_q == LoadW'($countones(busy_q)), "loaded count differs from busy flags")
  `NDAS_ASSERT(a_alloc_has_free, clk_i, rst_ni,
    ctl_i.alloc |-> has_free, "core load requested with no free core")
  `NDAS_ASSERT(a_alloc_rel_excl, clk_i, rst_ni,
    !(ctl_i.alloc && ctl_i.rel), "load and release requested together")

endmodule

`default_nettype wire
